// ===== sv/running_median_two_heaps_unit_macros.svh =====
// assertion macros shared by the running median checker
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH

// same-cycle implication
`define RMH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("running median check failed");

// next-cycle implication
`define RMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("running median check failed");

`endif

// ===== sv/rmh_pkg.sv =====
// shared types and constants for the running median unit
// no dependencies
`default_nettype none

package rmh_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DATA_W       = 32;

    // top-level sequencer
    typedef enum logic {
        T_IDLE,
        T_RUN
    } t_top_state;

    // sorted insertion walk inside one half
    typedef enum logic [1:0] {
        H_IDLE,
        H_WALK,
        H_PLACE
    } t_half_state;

    // command into one half
    typedef struct packed {
        logic                     start;
        logic                     replace;
        logic signed [DATA_W-1:0] value;
    } t_half_cmd;

    // status out of one half
    typedef struct packed {
        logic                     busy;
        logic signed [DATA_W-1:0] top;
    } t_half_stat;

endpackage

`default_nettype wire

// ===== sv/rmh_half.sv =====
// one half of the running median: sorted memory with an insertion walk
// depends on rmh_pkg
`default_nettype none

module rmh_half
    import rmh_pkg::*;
#(
    parameter int HALF_DEPTH = (DEF_CAPACITY + 1) / 2,
    parameter bit IS_LOWER   = 1'b1,
    localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1,
    localparam int CW = $clog2(HALF_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_half_cmd     i_cmd,
    output t_half_stat         o_stat,
    output logic [CW-1:0]      o_count
);

    // storage, top of the half at index count-1
    logic signed [DATA_W-1:0] mem [HALF_DEPTH];

    t_half_state              r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [AW-1:0]            r_idx, n_idx;
    logic                     r_first, n_first;
    logic signed [DATA_W-1:0] r_rd;

    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [CW-1:0]            w_base;
    logic                     w_beyond;

    assign w_base   = i_cmd.replace ? r_count - CW'(1) : r_count;
    assign w_beyond = IS_LOWER ? (r_rd > r_val) : (r_rd < r_val);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: begin
                if (i_cmd.start && (w_base != '0)) n_state = H_WALK;
            end
            H_WALK: begin
                if (!w_beyond)          n_state = H_IDLE;
                else if (r_idx == AW'(1)) n_state = H_PLACE;
            end
            H_PLACE: n_state = H_IDLE;
            default: n_state = H_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        n_val   = r_val;
        n_idx   = r_idx;
        n_first = r_first;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_val;
        unique case (r_state)
            H_IDLE: begin
                if (i_cmd.start) begin
                    n_count = w_base + CW'(1);
                    n_val   = i_cmd.value;
                    if (w_base == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = i_cmd.value;
                        n_top   = i_cmd.value;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(w_base - CW'(1));
                        n_idx   = AW'(w_base);
                        n_first = 1'b1;
                    end
                end
            end
            H_WALK: begin
                wr_en   = 1'b1;
                n_first = 1'b0;
                if (w_beyond) begin
                    // shift this entry up one place
                    wr_data = r_rd;
                    if (r_first) n_top = r_rd;
                    n_idx = r_idx - AW'(1);
                    if (r_idx != AW'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - AW'(2);
                    end
                end else begin
                    wr_data = r_val;
                    if (r_first) n_top = r_val;
                end
            end
            H_PLACE: begin
                wr_en   = 1'b1;
                wr_data = r_val;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_count <= '0;
            r_top   <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            r_first <= n_first;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_idx <= n_idx;
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd <= mem[rd_addr];
    end

    assign o_stat.busy = (r_state != H_IDLE);
    assign o_stat.top  = r_top;
    assign o_count     = r_count;

endmodule

`default_nettype wire

// ===== sv/running_median_two_heaps_unit.sv =====
// running median of signed 32-bit samples, lower and upper halves in two memories
// a sample is written straight into an empty half; otherwise the sorted-insertion walk
// moves one memory entry per cycle through a single read port
// one sample at a time; a dropped sample (capacity full) skips the walk
// reset: synchronous active low, both halves empty and the median back to zero
// no clearing pass: entries beyond each fill count are never read
`default_nettype none

module running_median_two_heaps_unit
    import rmh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2,
    localparam int CW = $clog2(HALF_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [31:0] sample
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [31:0] median
    output logic                   o_m_tuser    // [0] overflow
);

    t_top_state               r_state, n_state;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_med;
    logic                     r_out_ovf;
    logic signed [DATA_W-1:0] r_last_med;
    logic                     r_ovf, r_single, r_single_up;

    t_half_cmd                lo_cmd, up_cmd;
    t_half_stat               lo_stat, up_stat;
    logic [CW-1:0]            lo_count, up_count;

    logic signed [DATA_W-1:0] w_sample;
    logic [CW:0]              w_total;
    logic                     w_full, w_greater, w_accept, w_finish;
    logic signed [DATA_W:0]   w_sum, w_halfsum;
    logic signed [DATA_W-1:0] w_mean, w_median;

    assign w_sample  = $signed(i_s_tdata);
    assign w_total   = {1'b0, lo_count} + {1'b0, up_count};
    assign w_full    = (w_total >= (CW+1)'(CAPACITY));
    assign w_greater = (w_sample > r_last_med);
    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_finish  = (r_state == T_RUN) && !lo_stat.busy && !up_stat.busy
                       && (!r_out_valid || i_m_tready);

    // mean of the two tops, exact in 33 bits, truncated toward zero
    assign w_sum     = {lo_stat.top[DATA_W-1], lo_stat.top}
                     + {up_stat.top[DATA_W-1], up_stat.top};
    assign w_halfsum = (w_sum >>> 1) + (DATA_W+1)'(w_sum[DATA_W] & w_sum[0]);
    assign w_mean    = w_halfsum[DATA_W-1:0];

    always_comb begin
        if (r_ovf)         w_median = r_last_med;
        else if (r_single) w_median = r_single_up ? up_stat.top : lo_stat.top;
        else               w_median = w_mean;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:  if (w_accept) n_state = T_RUN;
            T_RUN:   if (w_finish) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    // half commands on accept
    always_comb begin
        lo_cmd = '{start: 1'b0, replace: 1'b0, value: w_sample};
        up_cmd = '{start: 1'b0, replace: 1'b0, value: w_sample};
        if (w_accept && !w_full) begin
            if (lo_count == up_count) begin
                if (w_greater) up_cmd.start = 1'b1;
                else           lo_cmd.start = 1'b1;
            end else if (lo_count > up_count) begin
                up_cmd.start = 1'b1;
                if (!w_greater) begin
                    // lower top crosses over, sample replaces it
                    up_cmd.value   = lo_stat.top;
                    lo_cmd.start   = 1'b1;
                    lo_cmd.replace = 1'b1;
                end
            end else begin
                lo_cmd.start = 1'b1;
                if (w_greater) begin
                    // upper top crosses over, sample replaces it
                    lo_cmd.value   = up_stat.top;
                    up_cmd.start   = 1'b1;
                    up_cmd.replace = 1'b1;
                end
            end
        end
    end

    assign o_s_tready = (r_state == T_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_med;
    assign o_m_tuser  = r_out_ovf;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
            r_last_med  <= '0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_out_valid <= 1'b1;
                r_last_med  <= w_median;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ovf       <= w_full;
            r_single    <= (lo_count == up_count);
            r_single_up <= w_greater;
        end
        if (w_finish) begin
            r_out_med <= w_median;
            r_out_ovf <= r_ovf;
        end
    end

    rmh_half #(.HALF_DEPTH(HALF_DEPTH), .IS_LOWER(1'b1)) u_lower (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (lo_cmd),
        .o_stat  (lo_stat),
        .o_count (lo_count)
    );

    rmh_half #(.HALF_DEPTH(HALF_DEPTH), .IS_LOWER(1'b0)) u_upper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (up_cmd),
        .o_stat  (up_stat),
        .o_count (up_count)
    );

endmodule

`default_nettype wire

// ===== sv/rmh_checker.sv =====
// port-level checks for the running median unit, bound to the top level
// depends on rmh_pkg and running_median_two_heaps_unit_macros.svh
`default_nettype none
`include "running_median_two_heaps_unit_macros.svh"

module rmh_checker
    import rmh_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic [DATA_W-1:0] i_s_tdata,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [DATA_W-1:0] o_m_tdata,
    input wire logic              o_m_tuser
);

    logic [DATA_W-1:0] r_prev_med;
    logic              w_in_xfer, w_out_xfer;

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_xfer = o_m_tvalid && i_m_tready;

    // median of the last result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prev_med <= '0;
        else if (w_out_xfer) r_prev_med <= o_m_tdata;
    end

    // stalled result holds
    `RMH_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // one sample at a time
    `RMH_ASSERT_NEXT(a_busy_after_in, w_in_xfer, !o_s_tready)
    // a dropped sample repeats the previous median
    `RMH_ASSERT_NOW(a_ovf_repeats, w_out_xfer && o_m_tuser, o_m_tdata == r_prev_med)

    // sample bus folded into one unused bit so that no input is left unconnected
    logic unused_in;
    assign unused_in = ^i_s_tdata;

endmodule

bind running_median_two_heaps_unit rmh_checker u_rmh_checker (.*);

`default_nettype wire
